[rtl/h2u_pkg.sv]
// h2u_pkg: widths, constants and shared types for the half-float RGB to
// unorm16 converter. No dependencies; imported by every other RTL file.
`default_nettype none

package h2u_pkg;

   localparam int HALF_W  = 16;
   localparam int UNORM_W = 16;
   localparam int EXP_W   = 5;
   localparam int FRAC_W  = 10;
   localparam int SIG_W   = FRAC_W + 1;
   localparam int PROD_W  = SIG_W + UNORM_W;    // 11 x 16 bit product
   localparam int ROUND_W = PROD_W + 1;         // room for the rounding add
   localparam int SHIFT_W = 5;

   localparam logic [UNORM_W-1:0] UNORM_MAX = 16'hFFFF;
   localparam logic [EXP_W-1:0]   EXP_SPECIAL = 5'h1F;  // inf / NaN
   localparam logic [EXP_W-1:0]   EXP_ONE     = 5'd15;  // 1.0 and up saturate
   localparam logic [EXP_W-1:0]   EXP_SUBNORM = 5'd0;
   localparam logic [SHIFT_W-1:0] SHIFT_SUBNORM = 5'd24;
   localparam logic [SHIFT_W-1:0] SHIFT_BIAS    = 5'd25;

   // How a lane builds its result after the product register
   typedef enum logic [1:0] {
      KIND_CALC = 2'd0,
      KIND_ZERO = 2'd1,
      KIND_SAT  = 2'd2
   } kind_type;

   // Pipeline control handed to the output stage
   typedef struct packed {
      logic load;
      logic valid;
   } ctrl_type;

endpackage

`default_nettype wire

[rtl/h2u_stream_if.sv]
// h2u_req_if / h2u_rsp_if: valid/ready channels for pixel transactions.
// Depends on h2u_pkg for the field widths.
`default_nettype none

interface h2u_req_if;
   import h2u_pkg::*;

   logic               valid;
   logic               ready;
   logic [HALF_W-1:0]  red_half;
   logic [HALF_W-1:0]  green_half;
   logic [HALF_W-1:0]  blue_half;

   modport source (output valid, output red_half, output green_half,
                   output blue_half, input ready);
   modport sink   (input valid, input red_half, input green_half,
                   input blue_half, output ready);
endinterface

interface h2u_rsp_if;
   import h2u_pkg::*;

   logic               valid;
   logic               ready;
   logic [UNORM_W-1:0] red_out;
   logic [UNORM_W-1:0] green_out;
   logic [UNORM_W-1:0] blue_out;

   modport source (output valid, output red_out, output green_out,
                   output blue_out, input ready);
   modport sink   (input valid, input red_out, input green_out,
                   input blue_out, output ready);
endinterface

`default_nettype wire

[rtl/h2u_lane.sv]
// h2u_lane: converts one binary16 channel word to unorm16. Registers the
// scaled significand, then rounds, shifts and clamps. Depends on h2u_pkg.
`default_nettype none

module h2u_lane (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic [h2u_pkg::HALF_W-1:0]  half_in,
   output logic      [h2u_pkg::UNORM_W-1:0] unorm_out
);
   import h2u_pkg::*;

   logic               sign;
   logic [EXP_W-1:0]   expo;
   logic [FRAC_W-1:0]  frac;
   logic [SIG_W-1:0]   sig;

   kind_type           kind_in,  kind_ff;
   logic [PROD_W-1:0]  prod_in,  prod_ff;
   logic [SHIFT_W-1:0] shift_in, shift_ff;

   logic [ROUND_W-1:0] round_sum;
   logic [ROUND_W-1:0] shifted;

   assign sign = half_in[HALF_W-1];
   assign expo = half_in[FRAC_W +: EXP_W];
   assign frac = half_in[FRAC_W-1:0];

   always_comb begin
      kind_in = KIND_CALC;
      if (expo == EXP_SPECIAL) begin
         kind_in = (frac != '0 || sign) ? KIND_ZERO : KIND_SAT;
      end else if (sign) begin
         kind_in = KIND_ZERO;
      end else if (expo >= EXP_ONE) begin
         kind_in = KIND_SAT;
      end

      if (expo == EXP_SUBNORM) begin
         sig      = {1'b0, frac};
         shift_in = SHIFT_SUBNORM;
      end else begin
         sig      = {1'b1, frac};
         shift_in = SHIFT_BIAS - expo;
      end
      prod_in = {{UNORM_W{1'b0}}, sig} * {{SIG_W{1'b0}}, UNORM_MAX};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         kind_ff  <= kind_in;
         prod_ff  <= prod_in;
         shift_ff <= shift_in;
      end
   end

   // shift is 11..24 on the arithmetic path; half the dropped weight rounds
   // ties away from zero
   assign round_sum = {1'b0, prod_ff} + (ROUND_W'(1) << (shift_ff - SHIFT_W'(1)));
   assign shifted   = round_sum >> shift_ff;

   always_comb begin
      case (kind_ff)
         KIND_ZERO: unorm_out = '0;
         KIND_SAT:  unorm_out = UNORM_MAX;
         KIND_CALC: unorm_out = (|shifted[ROUND_W-1:UNORM_W]) ? UNORM_MAX
                                                               : shifted[UNORM_W-1:0];
         default:   unorm_out = '0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/h2u_merge.sv]
// h2u_merge: gathers the three lane results into the response register
// and drives the response channel. Depends on h2u_pkg and h2u_rsp_if.
`default_nettype none

module h2u_merge (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire h2u_pkg::ctrl_type           ctrl,
   input  wire logic [h2u_pkg::UNORM_W-1:0] red_lane,
   input  wire logic [h2u_pkg::UNORM_W-1:0] green_lane,
   input  wire logic [h2u_pkg::UNORM_W-1:0] blue_lane,
   h2u_rsp_if.source                        rsp_chan
);
   import h2u_pkg::*;

   logic               valid_ff;
   logic [UNORM_W-1:0] red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load && ctrl.valid) begin
         red_ff   <= red_lane;
         green_ff <= green_lane;
         blue_ff  <= blue_lane;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.red_out   = red_ff;
   assign rsp_chan.green_out = green_ff;
   assign rsp_chan.blue_out  = blue_ff;

endmodule

`default_nettype wire

[rtl/half_rgb_to_unorm16_top.sv]
// half_rgb_to_unorm16_top: binary16 RGB pixel to unorm16 RGB converter.
// Depends on h2u_pkg, h2u_stream_if, h2u_lane and h2u_merge.
//
// Usage:
//   req_chan carries one pixel per transaction as three raw binary16 words;
//   rsp_chan returns the three unorm16 channels of that pixel, in order.
//   Each channel is value * 65535, rounded half away from zero, clamped to
//   0..65535; negatives, -0 and NaN give 0, +inf and values >= 1.0 give 65535.
//   Throughput is one pixel per clock unless rsp_chan stalls: three lanes
//   run in parallel, each with one 11x16 multiply registered ahead of the
//   round/shift/clamp, then the response register drives rsp_chan.
//   Two pipeline registers (lane product, response) hold up to two pixels,
//   so a new pixel is taken while a finished one waits on rsp_chan.
//   Stalls: rsp_chan.ready low holds the response; req_chan.ready drops
//   only once both registers are full.
//   Reset (synchronous, active high) empties the pipeline; req_chan.ready
//   is high in the first cycle after reset.
`default_nettype none

module half_rgb_to_unorm16_top (
   input  wire logic  clock,
   input  wire logic  reset,
   h2u_req_if.sink    req_chan,
   h2u_rsp_if.source  rsp_chan
);
   import h2u_pkg::*;

   logic               prod_valid_ff;
   logic               adv_out;
   logic               adv_lane;
   ctrl_type           merge_ctrl;
   logic [UNORM_W-1:0] red_lane, green_lane, blue_lane;

   // each stage advances when it is empty or the one after it moves
   assign adv_out  = !rsp_chan.valid || rsp_chan.ready;
   assign adv_lane = !prod_valid_ff || adv_out;
   assign req_chan.ready = adv_lane;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (adv_lane) begin
         prod_valid_ff <= req_chan.valid;
      end
   end

   h2u_lane u_lane_red (
      .clock     (clock),
      .enable    (adv_lane),
      .half_in   (req_chan.red_half),
      .unorm_out (red_lane)
   );

   h2u_lane u_lane_green (
      .clock     (clock),
      .enable    (adv_lane),
      .half_in   (req_chan.green_half),
      .unorm_out (green_lane)
   );

   h2u_lane u_lane_blue (
      .clock     (clock),
      .enable    (adv_lane),
      .half_in   (req_chan.blue_half),
      .unorm_out (blue_lane)
   );

   assign merge_ctrl.load  = adv_out;
   assign merge_ctrl.valid = prod_valid_ff;

   h2u_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (merge_ctrl),
      .red_lane   (red_lane),
      .green_lane (green_lane),
      .blue_lane  (blue_lane),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

[rtl/h2u_checker.sv]
// h2u_checker: port-level assertions for half_rgb_to_unorm16_top, attached
// by the bind below. Depends on h2u_pkg for widths and constants.
`default_nettype none

module h2u_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic [h2u_pkg::HALF_W-1:0]  red_half,
   input wire logic [h2u_pkg::HALF_W-1:0]  green_half,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [h2u_pkg::UNORM_W-1:0] red_out,
   input wire logic [h2u_pkg::UNORM_W-1:0] green_out
);
   import h2u_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(red_out) && $stable(green_out))
      else $error("response changed while stalled");

   // empty output register means the request side can never be blocked
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   // a transaction yields a valid response when the receiver takes the response
   assert property (@(posedge clock) disable iff (reset)
      req_xfer ##1 rsp_ready |=> rsp_valid)
      else $error("response missing two cycles after transaction");

   // negative red, including -0 and negative NaN/inf, maps to zero
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && red_half[HALF_W-1]) ##1 rsp_ready |=> red_out == '0)
      else $error("negative red did not give zero");

   // positive infinity on green saturates
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && green_half == 16'h7C00) ##1 rsp_ready |=> green_out == UNORM_MAX)
      else $error("positive infinity on green did not saturate");

endmodule

bind half_rgb_to_unorm16_top h2u_checker u_h2u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .red_half   (req_chan.red_half),
   .green_half (req_chan.green_half),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .red_out    (rsp_chan.red_out),
   .green_out  (rsp_chan.green_out)
);

`default_nettype wire
